// File: src/tba_pkg.sv
// Shared widths, codes and interface types of the time bucket aggregator.
package tba_pkg;

   // Field and state widths
   localparam int TIME_W    = 32;
   localparam int VAL_W     = 32;
   localparam int ACC_W     = 48;
   localparam int CNT_W     = 16;
   localparam int METHOD_W  = 2;

   // Stream and register port widths
   localparam int REQ_TDATA_W = TIME_W + VAL_W;
   localparam int RSP_TDATA_W = TIME_W + VAL_W;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // Empty buckets reported per closing sample before the skip-ahead
   localparam int MAX_EMPTY_RESULTS = 63;
   localparam int GAP_W             = $clog2(MAX_EMPTY_RESULTS + 1);

   // Bit-serial divider: long divides the accumulator, short divides a time
   localparam int DIV_N_W   = ACC_W;
   localparam int DIV_D_W   = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES   = 2'd2;

   // Aggregation codes; every other code means average
   localparam logic [METHOD_W-1:0] AGG_LOWEST  = 2'd1;
   localparam logic [METHOD_W-1:0] AGG_HIGHEST = 2'd2;

   // Effective configuration, zero length and zero minimum already mapped to one
   typedef struct packed {
      logic [TIME_W-1:0]   length;
      logic [METHOD_W-1:0] method;
      logic [CNT_W-1:0]    need;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic               short_op;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
      logic [DIV_D_W-1:0] remainder;
   } div_stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST_DIV,
      S_AVG_DIV,
      S_GAP_START,
      S_GAP_DIV,
      S_EMIT_CLOSE,
      S_EMIT_GAP
   } state_type;

endpackage

// File: src/time_bucket_aggregator.sv
// Top level: configuration registers, bucket sequencer and shared serial divider.
//
// Input transactions on req_*: one timestamped sample each, nondecreasing
// in time. Result transactions on rsp_*: one per closed or skipped bucket,
// rsp_tlast marking the final result caused by one sample. Configuration
// is written through csr_we/csr_index/csr_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// A sample inside the open bucket gives no result. The first sample after
// reset holds req_tready low for the 32-step serial division that aligns
// the bucket start. A sample that closes a bucket holds req_tready low for
// a 48-step division of the sum (valid average only), a 32-step division
// of the gap, both on the one-bit-per-cycle divider, and its results: one
// result per cycle while rsp_tready is high, up to 64 results.
// A result waits in the output register while the next sample is taken.
// When the receiver stalls, the sequencer holds until the register frees.
// Reset restores the register defaults (length 60, average, one sample)
// and returns to the state before the first sample; no result is pending.
module time_bucket_aggregator (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = timestamp[31:0], sample_value[63:32]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tba_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // request: tuser = sample_finite[0]
   input  logic                              req_tuser,
   // response: tdata = bucket_time[31:0], aggregate[63:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tba_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // response: tuser = aggregate_valid[0], gaps_dropped[1]
   output logic [tba_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [tba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tba_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tba_pkg::*;

   logic [TIME_W-1:0]   len_ff, len_in;
   logic [METHOD_W-1:0] method_ff, method_in;
   logic [CNT_W-1:0]    minsamp_ff, minsamp_in;
   cfg_type             cfg;
   div_cmd_type         div_cmd;
   div_stat_type        div_stat;

   // Register writes
   always_comb begin
      len_in     = len_ff;
      method_in  = method_ff;
      minsamp_in = minsamp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BUCKET_LENGTH: len_in     = csr_wdata[TIME_W-1:0];
            CSR_METHOD:        method_in  = csr_wdata[METHOD_W-1:0];
            CSR_MIN_SAMPLES:   minsamp_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= TIME_W'(60);
         method_ff  <= '0;
         minsamp_ff <= CNT_W'(1);
      end else begin
         len_ff     <= len_in;
         method_ff  <= method_in;
         minsamp_ff <= minsamp_in;
      end
   end

   // Zero length and zero minimum both act as one
   assign cfg.length = (len_ff == '0) ? TIME_W'(1) : len_ff;
   assign cfg.method = method_ff;
   assign cfg.need   = (minsamp_ff == '0) ? CNT_W'(1) : minsamp_ff;

   tba_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   tba_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .div_cmd    (div_cmd),
      .div_stat   (div_stat)
   );

endmodule

// File: src/tba_serial_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module tba_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tba_pkg::div_cmd_type  cmd,
   output tba_pkg::div_stat_type stat
);
   import tba_pkg::*;

   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;

   // One restoring step; dividend bits leave the top of the quotient register
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         busy_in = 1'b1;
         if (cmd.short_op) begin
            // time-wide dividend sits at the top, so the step count shrinks
            quo_in = {cmd.dividend[TIME_W-1:0], {(DIV_N_W-TIME_W){1'b0}}};
            cnt_in = DIV_CNT_W'(TIME_W);
         end else begin
            quo_in = cmd.dividend;
            cnt_in = DIV_CNT_W'(DIV_N_W);
         end
      end else if (busy_ff) begin
         if (!diff[DIV_D_W]) begin
            rem_in = diff[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

   // A running division always has steps left
   a_busy_count : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");

endmodule

// File: src/tba_core.sv
// Bucket sequencer: accumulation, bucket closing, gap results and output register.
module tba_core (
   input  logic                                clock,
   input  logic                                reset,
   input  tba_pkg::cfg_type                    cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tba_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tba_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [tba_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   output tba_pkg::div_cmd_type                div_cmd,
   input  tba_pkg::div_stat_type               div_stat
);
   import tba_pkg::*;

   state_type          state_ff, state_in;
   logic               started_ff, started_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  ts_ff, ts_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic               fin_ff, fin_in;
   logic [VAL_W-1:0]   agg_ff, agg_in;
   logic               aggv_ff, aggv_in;
   logic               neg_ff, neg_in;
   logic               gaps_ff, gaps_in;
   logic [GAP_W-1:0]   gap_left_ff, gap_left_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TIME_W-1:0]  nstart_ff, nstart_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic [VAL_W-1:0]   rsp_agg_ff, rsp_agg_in;
   logic               rsp_aggv_ff, rsp_aggv_in;
   logic               rsp_gaps_ff, rsp_gaps_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [TIME_W-1:0]  in_ts;
   logic [VAL_W-1:0]   in_val;
   logic [ACC_W-1:0]   in_ext;
   logic [ACC_W-1:0]   held_ext;
   logic [TIME_W:0]    bucket_end;
   logic               accept;
   logic               out_free;
   logic               is_avg;
   logic               finish;
   logic [TIME_W-1:0]  k_val;

   assign in_ts      = req_tdata[TIME_W-1:0];
   assign in_val     = req_tdata[TIME_W+VAL_W-1:TIME_W];
   assign in_ext     = {{(ACC_W-VAL_W){in_val[VAL_W-1]}}, in_val};
   assign held_ext   = {{(ACC_W-VAL_W){val_ff[VAL_W-1]}}, val_ff};
   assign bucket_end = {1'b0, start_ff} + {1'b0, cfg.length};
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_avg     = (cfg.method != AGG_LOWEST) && (cfg.method != AGG_HIGHEST);
   assign k_val      = div_stat.quotient[TIME_W-1:0];

   // Sequencer: next state, datapath updates and divider commands
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      start_in     = start_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      ts_in        = ts_ff;
      val_in       = val_ff;
      fin_in       = fin_ff;
      agg_in       = agg_ff;
      aggv_in      = aggv_ff;
      neg_in       = neg_ff;
      gaps_in      = gaps_ff;
      gap_left_in  = gap_left_ff;
      time_in      = time_ff;
      nstart_in    = nstart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_time_in  = rsp_time_ff;
      rsp_agg_in   = rsp_agg_ff;
      rsp_aggv_in  = rsp_aggv_ff;
      rsp_gaps_in  = rsp_gaps_ff;
      rsp_last_in  = rsp_last_ff;
      div_cmd      = '0;
      finish       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ts_in  = in_ts;
               val_in = in_val;
               fin_in = req_tuser;
               if (!started_ff) begin
                  // align the first bucket: start = ts - ts mod length
                  div_cmd.start    = 1'b1;
                  div_cmd.short_op = 1'b1;
                  div_cmd.dividend = {{(DIV_N_W-TIME_W){1'b0}}, in_ts};
                  div_cmd.divisor  = cfg.length;
                  state_in         = S_FIRST_DIV;
               end else if ({1'b0, in_ts} < bucket_end) begin
                  // sample falls in the open bucket; a full count ignores it
                  if (req_tuser && (cnt_ff != '1)) begin
                     case (cfg.method)
                        AGG_LOWEST: begin
                           if ((cnt_ff == '0) || ($signed(in_ext) < $signed(acc_ff)))
                              acc_in = in_ext;
                        end
                        AGG_HIGHEST: begin
                           if ((cnt_ff == '0) || ($signed(in_ext) > $signed(acc_ff)))
                              acc_in = in_ext;
                        end
                        default: acc_in = acc_ff + in_ext;
                     endcase
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  // close the bucket
                  aggv_in = (cnt_ff >= cfg.need);
                  if ((cnt_ff >= cfg.need) && is_avg) begin
                     div_cmd.start    = 1'b1;
                     div_cmd.short_op = 1'b0;
                     div_cmd.dividend = acc_ff[ACC_W-1] ? (-acc_ff) : acc_ff;
                     div_cmd.divisor  = {{(DIV_D_W-CNT_W){1'b0}}, cnt_ff};
                     neg_in           = acc_ff[ACC_W-1];
                     state_in         = S_AVG_DIV;
                  end else begin
                     agg_in   = (cnt_ff >= cfg.need) ? acc_ff[VAL_W-1:0] : '0;
                     state_in = S_GAP_START;
                  end
               end
            end
         end

         S_FIRST_DIV: begin
            if (div_stat.done) begin
               started_in = 1'b1;
               start_in   = ts_ff - div_stat.remainder;
               acc_in     = fin_ff ? held_ext : '0;
               cnt_in     = {{(CNT_W-1){1'b0}}, fin_ff};
               state_in   = S_IDLE;
            end
         end

         S_AVG_DIV: begin
            // truncation toward zero: divide the magnitude, restore the sign
            if (div_stat.done) begin
               agg_in   = neg_ff ? (-div_stat.quotient[VAL_W-1:0])
                                 : div_stat.quotient[VAL_W-1:0];
               state_in = S_GAP_START;
            end
         end

         S_GAP_START: begin
            // empty buckets passed over: (ts - next) / length
            div_cmd.start    = 1'b1;
            div_cmd.short_op = 1'b1;
            div_cmd.dividend = {{(DIV_N_W-TIME_W){1'b0}}, ts_ff - start_ff - cfg.length};
            div_cmd.divisor  = cfg.length;
            state_in         = S_GAP_DIV;
         end

         S_GAP_DIV: begin
            if (div_stat.done) begin
               gaps_in     = (k_val > TIME_W'(MAX_EMPTY_RESULTS));
               gap_left_in = (k_val > TIME_W'(MAX_EMPTY_RESULTS))
                             ? GAP_W'(MAX_EMPTY_RESULTS) : k_val[GAP_W-1:0];
               nstart_in   = ts_ff - div_stat.remainder;
               time_in     = start_ff + cfg.length;
               state_in    = S_EMIT_CLOSE;
            end
         end

         S_EMIT_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = start_ff;
               rsp_agg_in   = agg_ff;
               rsp_aggv_in  = aggv_ff;
               rsp_gaps_in  = gaps_ff;
               rsp_last_in  = (gap_left_ff == '0);
               if (gap_left_ff == '0)
                  finish = 1'b1;
               else
                  state_in = S_EMIT_GAP;
            end
         end

         S_EMIT_GAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = time_ff;
               rsp_agg_in   = '0;
               rsp_aggv_in  = 1'b0;
               rsp_gaps_in  = gaps_ff;
               rsp_last_in  = (gap_left_ff == GAP_W'(1));
               gap_left_in  = gap_left_ff - 1'b1;
               time_in      = time_ff + cfg.length;
               if (gap_left_ff == GAP_W'(1))
                  finish = 1'b1;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // open the bucket that holds the closing sample
      if (finish) begin
         start_in = nstart_ff;
         acc_in   = fin_ff ? held_ext : '0;
         cnt_in   = {{(CNT_W-1){1'b0}}, fin_ff};
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         start_ff     <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         gap_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         start_ff     <= start_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         gap_left_ff  <= gap_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ts_ff       <= ts_in;
      val_ff      <= val_in;
      fin_ff      <= fin_in;
      agg_ff      <= agg_in;
      aggv_ff     <= aggv_in;
      neg_ff      <= neg_in;
      gaps_ff     <= gaps_in;
      time_ff     <= time_in;
      nstart_ff   <= nstart_in;
      rsp_time_ff <= rsp_time_in;
      rsp_agg_ff  <= rsp_agg_in;
      rsp_aggv_ff <= rsp_aggv_in;
      rsp_gaps_ff <= rsp_gaps_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_agg_ff, rsp_time_ff};
   assign rsp_tuser  = {rsp_gaps_ff, rsp_aggv_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_div_free : assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_stat.busy)
      else $error("division started while divider busy");

   a_started_holds : assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag cleared outside reset");

   a_gap_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_GAP) |->
         (gap_left_ff != '0) && (gap_left_ff <= GAP_W'(MAX_EMPTY_RESULTS)))
      else $error("gap result count out of range");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_aggv_ff) |-> (rsp_agg_ff == '0))
      else $error("invalid bucket carries a nonzero aggregate");

endmodule
